>>> rtl/crockford_base32_encoder_top_assert.svh
// Assertion macros for the Crockford base32 encoder checker.
// No dependencies; included by the checker file only.
`ifndef CROCKFORD_BASE32_ENCODER_TOP_ASSERT_SVH
`define CROCKFORD_BASE32_ENCODER_TOP_ASSERT_SVH

// Check a property while reset is released.
`define CB32_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define CB32_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/cb32_pkg.sv
// Shared types and the symbol table of the Crockford base32 encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package cb32_pkg;

    // Work for one byte: up to three 5-bit groups, how many are used, end mark.
    typedef struct packed {
        logic [4:0] g0;
        logic [4:0] g1;
        logic [4:0] g2;
        logic [1:0] cnt;
        logic       last;
    } t_job;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] C_ALPHA [0:31] = '{
        "0", "1", "2", "3", "4", "5", "6", "7",
        "8", "9", "A", "B", "C", "D", "E", "F",
        "G", "H", "J", "K", "M", "N", "P", "Q",
        "R", "S", "T", "V", "W", "X", "Y", "Z"
    };

    // Map a 5-bit group to its 7-bit ASCII symbol.
    function automatic logic [6:0] symbol_of(input logic [4:0] grp);
        logic [7:0] ch;
        ch = C_ALPHA[grp];
        return ch[6:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/cb32_front.sv
// Front end: takes message bytes, merges them with pending bits, and
// splits the result into 5-bit groups. Depends on cb32_pkg.
`default_nettype none

module cb32_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_data,
    input  wire logic         i_last,
    output cb32_pkg::t_job    o_job
);

    logic [3:0]  r_left;
    logic [2:0]  r_cnt;
    logic [3:0]  n_left;
    logic [2:0]  n_cnt;

    logic [11:0] w_full;
    logic [3:0]  w_total;
    logic [2:0]  w_shift;
    logic [11:0] w_win;
    logic        w_two;
    logic [2:0]  w_rem;
    logic [4:0]  w_mask;

    always_comb begin
        w_full  = {r_left, i_data};
        w_total = {1'b0, r_cnt} + 4'd8;
        w_shift = 3'(4'd12 - w_total);
        // Left-align the valid bits; zeros shift in for the final pad.
        w_win   = w_full << w_shift;
        w_two   = (w_total >= 4'd10);
        w_rem   = w_two ? 3'(w_total - 4'd10) : 3'(w_total - 4'd5);
        w_mask  = 5'((5'd1 << w_rem) - 5'd1);

        o_job.g0   = w_win[11:7];
        o_job.g1   = w_win[6:2];
        o_job.g2   = {w_win[1:0], 3'b000};
        o_job.cnt  = (w_two ? 2'd2 : 2'd1) + {1'b0, (i_last && (w_rem != 3'd0))};
        o_job.last = i_last;

        n_left = i_last ? 4'd0 : (w_full[3:0] & w_mask[3:0]);
        n_cnt  = i_last ? 3'd0 : w_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
            r_cnt  <= 3'd0;
        end else if (i_accept) begin
            r_left <= n_left;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cb32_queue.sv
// Two-entry queue of group jobs between the front and back ends.
// Depends on cb32_pkg.
`default_nettype none

module cb32_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire cb32_pkg::t_job i_job,
    input  wire logic         i_pop,
    output cb32_pkg::t_job    o_job,
    output logic              o_valid,
    output logic              o_full
);

    cb32_pkg::t_job r_mem [cb32_pkg::QUEUE_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    assign o_job   = r_mem[r_rp];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'(cb32_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/cb32_back.sv
// Back end: steps through the groups of each job and drives one symbol per
// cycle into the output register while it is not stalled. Depends on cb32_pkg.
`default_nettype none

module cb32_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire cb32_pkg::t_job i_job,
    input  wire logic         i_job_valid,
    output logic              o_pop,
    output logic              o_valid,
    output logic [6:0]        o_symbol,
    output logic              o_last,
    input  wire logic         i_ready
);

    cb32_pkg::t_job r_job;
    logic           r_busy;
    logic [1:0]     r_idx;
    logic           r_ovalid;
    logic [6:0]     r_sym;
    logic           r_olast;

    logic [4:0]     w_grp;
    logic           w_free;
    logic           w_emit;
    logic           w_end;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_grp = r_job.g0;
            2'd1:    w_grp = r_job.g1;
            default: w_grp = r_job.g2;
        endcase
        w_free = !r_ovalid || i_ready;
        w_emit = r_busy && w_free;
        w_end  = (r_idx == (r_job.cnt - 2'd1));
        // Take the next job when idle, or as the current one hands over its final symbol.
        o_pop  = i_job_valid && (!r_busy || (w_emit && w_end));
    end

    assign o_valid  = r_ovalid;
    assign o_symbol = r_sym;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sym   <= cb32_pkg::symbol_of(w_grp);
            r_olast <= r_job.last && w_end;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_emit) begin
                r_idx <= r_idx + 2'd1;
                if (w_end) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/crockford_base32_encoder_top.sv
// Top level of the Crockford base32 encoder: front end, job queue, back end.
// Depends on cb32_pkg, cb32_front, cb32_queue and cb32_back.
`default_nettype none

// Crockford base32 encoder. Feed a message one byte per item on the slave
// stream, tlast high on its final byte; symbols leave on the master stream
// as ASCII, most significant bits first, tlast high on the final symbol of
// the message. A byte yields one or two symbols, the final byte up to three
// (the last one zero-padded); no '=' padding is ever produced. The front end
// turns a byte into a job in the same cycle it is accepted and pushes it into
// a two-entry queue, so bytes are taken on consecutive cycles as long as the
// queue has room. The back end sends one symbol per cycle while the master
// stream is ready, through a single output register, and this register port
// sets the sustained rate, with the symbols of successive bytes following
// back to back. Into an empty block, a byte's job passes through the queue
// entry and the back end's job register before its first symbol is registered.
module crockford_base32_encoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] symbol, [7] zero fill
    output logic            m_axis_tlast    // last_symbol
);

    cb32_pkg::t_job w_front_job;
    cb32_pkg::t_job w_head_job;
    logic           w_accept;
    logic           w_q_valid;
    logic           w_q_full;
    logic           w_pop;
    logic [6:0]     w_symbol;

    // Accept a byte whenever the queue has a free entry.
    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    cb32_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_job    (w_front_job)
    );

    cb32_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    cb32_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_valid (w_q_valid),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .o_symbol    (w_symbol),
        .o_last      (m_axis_tlast),
        .i_ready     (m_axis_tready)
    );

    // Pad the 7-bit symbol to a whole byte.
    assign m_axis_tdata = {1'b0, w_symbol};

endmodule

`default_nettype wire

>>> rtl/cb32_checker.sv
// Port-level checks for the Crockford base32 encoder, bound to its top level.
// Depends on crockford_base32_encoder_top_assert.svh.
`default_nettype none

`include "crockford_base32_encoder_top_assert.svh"

module cb32_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] i_m_tdata,
    input wire logic       i_m_tlast
);

    // Hold a stalled symbol.
    `CB32_ASSERT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid, "output valid dropped while stalled")
    `CB32_ASSERT(a_hold_data, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata) && $stable(i_m_tlast), "stalled symbol changed")
    // Symbols stay inside the alphabet range.
    `CB32_ASSERT(a_range, i_clk, i_rst_n, i_m_tvalid |-> (i_m_tdata >= 8'd48) && (i_m_tdata <= 8'd90), "symbol out of range")
    // Letters dropped from the alphabet, and the signs between digits and letters, never appear.
    `CB32_ASSERT(a_no_excluded, i_clk, i_rst_n, i_m_tvalid |-> (i_m_tdata != "I") && (i_m_tdata != "L") && (i_m_tdata != "O") && (i_m_tdata != "U") && ((i_m_tdata <= 8'd57) || (i_m_tdata >= 8'd65)), "symbol not in alphabet")
    // Reset empties the output register.
    `CB32_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_m_tvalid, "output valid after reset")

endmodule

bind crockford_base32_encoder_top cb32_checker u_cb32_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);

`default_nettype wire
